FILE: hw/rtl/fixed_point_word_to_decimal_text_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point to decimal text converter.
// Each macro expands to a labeled concurrent assertion, or to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_WORD_TO_DECIMAL_TEXT_ASSERT_SVH
`define FIXED_POINT_WORD_TO_DECIMAL_TEXT_ASSERT_SVH

`ifndef ASSERT_OFF
`define FPDT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPDT_ASSERT_PAST(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ($past(rst_n) && $past(cond)) |-> prop) else $error(msg);
`else
`define FPDT_ASSERT(label, clk, rst_n, prop, msg)
`define FPDT_ASSERT_PAST(label, clk, rst_n, cond, prop, msg)
`endif

`endif

FILE: hw/rtl/fpdt_pkg.sv
// ----------------------------------------------------------------------------
// fpdt_pkg
// Shared constants, types and elaboration helpers for the fixed-point to
// decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpdt_pkg;

    localparam int WORD_W        = 32;
    localparam int INT_BITS_DEF  = 24;
    localparam int FRAC_BITS_DEF = 7;
    localparam int CHAR_W        = 6;
    localparam int BCD_W         = 4;

    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

    typedef enum logic [2:0] {
        EM_IDLE,
        EM_SIGN,
        EM_INT,
        EM_POINT,
        EM_FRAC
    } t_emit_state;

    // Status of the converter toward the character emitter.
    typedef struct packed {
        logic done;
        logic neg;
    } t_conv_status;

    // Number of decimal digits needed for the largest value of a bit count.
    function automatic int dec_digits(input int bits);
        longint unsigned v;
        int n;
        v = (64'd1 << bits) - 64'd1;
        n = 1;
        while (v >= 64'd10) begin
            v = v / 10;
            n++;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fpdt_bcd_cell.sv
// ----------------------------------------------------------------------------
// fpdt_bcd_cell
// One decimal digit of the shift-and-add-3 converter. Each step shifts two
// binary bits through the digit and hands the overflow bits to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpdt_bcd_cell (
    input  logic                        i_clk,
    input  logic                        i_clear,
    input  logic                        i_step,
    input  logic [1:0]                  i_carry,
    output logic [1:0]                  o_carry,
    output logic [fpdt_pkg::BCD_W-1:0]  o_digit
);
    import fpdt_pkg::*;

    logic [BCD_W-1:0] r_digit;
    logic [BCD_W-1:0] n_digit;
    logic [BCD_W-1:0] w_adj1;
    logic [BCD_W-1:0] w_mid;
    logic [BCD_W-1:0] w_adj2;

    // Two dependent shift steps: the upper carry bit enters first.
    always_comb begin
        w_adj1  = (r_digit >= BCD_W'(5)) ? r_digit + BCD_W'(3) : r_digit;
        w_mid   = {w_adj1[BCD_W-2:0], i_carry[1]};
        w_adj2  = (w_mid >= BCD_W'(5)) ? w_mid + BCD_W'(3) : w_mid;
        o_carry = {w_adj1[BCD_W-1], w_adj2[BCD_W-1]};
        n_digit = r_digit;
        if (i_clear) begin
            n_digit = '0;
        end else if (i_step) begin
            n_digit = {w_adj2[BCD_W-2:0], i_carry[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

`default_nettype wire

FILE: hw/rtl/fpdt_convert.sv
// ----------------------------------------------------------------------------
// fpdt_convert
// Input stage: splits the word into sign, integer and fraction and runs the
// integer through a chain of BCD cells, two bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_point_word_to_decimal_text_assert.svh"

module fpdt_convert #(
    parameter int INT_BITS  = fpdt_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = fpdt_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [fpdt_pkg::WORD_W-1:0]            i_fixed_word,
    input  logic                                   i_take,
    output fpdt_pkg::t_conv_status                 o_status,
    output logic [FRAC_BITS-1:0]                   o_frac,
    output logic [fpdt_pkg::dec_digits(INT_BITS)*fpdt_pkg::BCD_W-1:0] o_digits
);
    import fpdt_pkg::*;

    localparam int ND        = dec_digits(INT_BITS);
    localparam int STEPS     = (INT_BITS + 1) / 2;
    localparam int PAD_W     = 2 * STEPS;
    localparam int CNT_W     = $clog2(STEPS + 1);
    localparam int SIGN_LSB  = INT_BITS + FRAC_BITS;
    localparam int INT_AVAIL = (WORD_W - FRAC_BITS < INT_BITS) ? WORD_W - FRAC_BITS : INT_BITS;

    logic                 r_full, n_full;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [PAD_W-1:0]     r_bits, n_bits;
    logic                 r_neg, n_neg;
    logic [FRAC_BITS-1:0] r_frac, n_frac;

    logic                 w_accept;
    logic                 w_done;
    logic                 w_step;
    logic                 w_neg_in;
    logic [WORD_W-1:0]    w_shifted;
    logic [PAD_W-1:0]     w_ipad;
    logic [1:0]           w_carry [ND+1];

    // Any set bit above the integer field marks a negative word.
    generate
        if (SIGN_LSB < WORD_W) begin : g_sign
            assign w_neg_in = |i_fixed_word[WORD_W-1:SIGN_LSB];
        end else begin : g_nosign
            assign w_neg_in = 1'b0;
        end
    endgenerate

    assign w_shifted  = i_fixed_word >> FRAC_BITS;
    assign w_ipad     = PAD_W'(w_shifted[INT_AVAIL-1:0]);
    assign w_done     = r_full && (r_cnt == '0);
    assign w_step     = r_full && (r_cnt != '0);
    assign o_in_ready = !r_full || i_take;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_full = r_full;
        n_cnt  = r_cnt;
        n_bits = r_bits;
        n_neg  = r_neg;
        n_frac = r_frac;
        if (i_take) begin
            n_full = 1'b0;
        end
        if (w_step) begin
            n_cnt  = r_cnt - CNT_W'(1);
            n_bits = r_bits << 2;
        end
        if (w_accept) begin
            n_full = 1'b1;
            n_cnt  = CNT_W'(STEPS);
            n_bits = w_ipad;
            n_neg  = w_neg_in;
            n_frac = i_fixed_word[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_full <= n_full;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_neg  <= n_neg;
        r_frac <= n_frac;
    end

    // The two most significant pending bits feed the least significant digit.
    assign w_carry[0] = r_bits[PAD_W-1 -: 2];

    generate
        for (genvar k = 0; k < ND; k++) begin : g_cell
            fpdt_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_clear (w_accept),
                .i_step  (w_step),
                .i_carry (w_carry[k]),
                .o_carry (w_carry[k+1]),
                .o_digit (o_digits[k*BCD_W +: BCD_W])
            );
        end
    endgenerate

    assign o_status.done = w_done;
    assign o_status.neg  = r_neg;
    assign o_frac        = r_frac;

    `FPDT_ASSERT(a_cnt_needs_word, i_clk, i_rst_n, (r_cnt != '0) |-> r_full, "count running without a word")
    `FPDT_ASSERT(a_no_overflow, i_clk, i_rst_n, w_step |-> (w_carry[ND] == 2'b00), "BCD chain overflow")
    `FPDT_ASSERT(a_take_when_done, i_clk, i_rst_n, i_take |-> w_done, "result taken before conversion ended")

endmodule

`default_nettype wire

FILE: hw/rtl/fpdt_emit.sv
// ----------------------------------------------------------------------------
// fpdt_emit
// Output stage: walks sign, integer digits, point and fraction digits and
// sends one character per cycle while the receiver is ready, through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_point_word_to_decimal_text_assert.svh"

module fpdt_emit #(
    parameter int INT_BITS  = fpdt_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = fpdt_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fpdt_pkg::t_conv_status                 i_status,
    input  logic [FRAC_BITS-1:0]                   i_frac,
    input  logic [fpdt_pkg::dec_digits(INT_BITS)*fpdt_pkg::BCD_W-1:0] i_digits,
    output logic                                   o_take,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [fpdt_pkg::CHAR_W-1:0]            o_text_char,
    output logic                                   o_last_char
);
    import fpdt_pkg::*;

    localparam int ND     = dec_digits(INT_BITS);
    localparam int IDX_W  = (ND > 1) ? $clog2(ND) : 1;
    localparam int PROD_W = FRAC_BITS + 4;

    t_emit_state          r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [FRAC_BITS-1:0] r_frac, n_frac;
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic                 r_last, n_last;
    logic [BCD_W-1:0]     r_digits [ND];

    logic                 w_free;
    logic                 w_adv;
    logic [CHAR_W-1:0]    w_char;
    logic                 w_last;
    logic [IDX_W-1:0]     w_top;
    logic [PROD_W-1:0]    w_prod;
    logic [BCD_W-1:0]     w_fdig;
    logic [FRAC_BITS-1:0] w_frem;

    assign w_free = !r_out_valid || i_out_ready;
    assign w_adv  = w_free && (r_state != EM_IDLE);

    // Fraction times ten: the integer overflow is the next digit.
    assign w_prod = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};
    assign w_fdig = w_prod[PROD_W-1:FRAC_BITS];
    assign w_frem = w_prod[FRAC_BITS-1:0];

    // Most significant nonzero digit, or the units digit for zero.
    always_comb begin
        w_top = '0;
        for (int k = 1; k < ND; k++) begin
            if (i_digits[k*BCD_W +: BCD_W] != '0) begin
                w_top = IDX_W'(k);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_frac      = r_frac;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        w_char      = CH_ZERO;
        w_last      = 1'b0;
        case (r_state)
            EM_SIGN: begin
                w_char = CH_MINUS;
                if (w_adv) begin
                    n_state = EM_INT;
                end
            end
            EM_INT: begin
                w_char = CH_ZERO + CHAR_W'(r_digits[r_idx]);
                if (w_adv) begin
                    if (r_idx == '0) begin
                        n_state = EM_POINT;
                    end else begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end
            end
            EM_POINT: begin
                w_char = CH_POINT;
                if (w_adv) begin
                    n_state = EM_FRAC;
                end
            end
            EM_FRAC: begin
                // Ends at the digit leaving a zero remainder; only a zero fraction ends in 0.
                w_char = CH_ZERO + CHAR_W'(w_fdig);
                w_last = (w_frem == '0);
                if (w_adv) begin
                    n_frac = w_frem;
                    if (w_last) begin
                        n_state = EM_IDLE;
                    end
                end
            end
            EM_IDLE: begin
            end
            default: begin
                n_state = EM_IDLE;
            end
        endcase

        o_take = i_status.done && ((r_state == EM_IDLE) || (w_adv && w_last));
        if (o_take) begin
            n_state = i_status.neg ? EM_SIGN : EM_INT;
            n_idx   = w_top;
            n_frac  = i_frac;
        end

        if (w_free) begin
            n_out_valid = w_adv;
            n_char      = w_char;
            n_last      = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EM_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            for (int k = 0; k < ND; k++) begin
                r_digits[k] <= i_digits[k*BCD_W +: BCD_W];
            end
        end
        r_idx  <= n_idx;
        r_frac <= n_frac;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

    `FPDT_ASSERT(a_int_digit_bcd, i_clk, i_rst_n,
        (r_state == EM_INT) |-> (r_digits[r_idx] <= BCD_W'(9)), "integer digit is not decimal")
    `FPDT_ASSERT_PAST(a_no_lead_zero, i_clk, i_rst_n, o_take,
        (r_idx == '0) || (r_digits[r_idx] != '0), "leading zero digit")
    `FPDT_ASSERT_PAST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_text_char) && $stable(o_last_char), "stalled word changed")

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_point_word_to_decimal_text.sv
// Throughput: one character per cycle while the receiver is ready; a word has 3 to 17
// characters by default. The character emitter sends one word while the two-bits-per-cycle
// BCD cell chain converts the next word, so a short text can leave the emitter waiting.
// Reset: synchronous, active low; clears the handshake and sequencing state only.
// ----------------------------------------------------------------------------
// fixed_point_word_to_decimal_text
// Converts a sign-magnitude fixed-point word into a stream of ASCII
// characters: optional minus, integer digits, point and fraction digits.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_word_to_decimal_text #(
    parameter int INT_BITS  = fpdt_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS = fpdt_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [fpdt_pkg::WORD_W-1:0]   i_fixed_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fpdt_pkg::CHAR_W-1:0]   o_text_char,
    output logic                          o_last_char
);
    import fpdt_pkg::*;

    localparam int ND = dec_digits(INT_BITS);

    t_conv_status            w_status;
    logic [FRAC_BITS-1:0]    w_frac;
    logic [ND*BCD_W-1:0]     w_digits;
    logic                    w_take;

    fpdt_convert #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_fixed_word (i_fixed_word),
        .i_take       (w_take),
        .o_status     (w_status),
        .o_frac       (w_frac),
        .o_digits     (w_digits)
    );

    fpdt_emit #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (w_status),
        .i_frac      (w_frac),
        .i_digits    (w_digits),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire

FILE: verif/fixed_point_word_to_decimal_text_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_word_to_decimal_text_tb
// Sends sign-magnitude fixed-point words into the decimal text converter and
// checks every character it returns, with its last flag, against a local
// prediction. A short directed list comes first, then random words under
// several idle and stall patterns on the two handshakes.
// ----------------------------------------------------------------------------

// Predicts the text of each accepted word and checks returned characters.
class decimal_text_board;

    typedef struct packed {
        logic [fpdt_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_text_char;

    t_text_char expected_chars[$];
    int         errors;
    int         words_seen;
    int         chars_seen;
    int         neg_words;
    int         longest;

    function int pending();
        return expected_chars.size();
    endfunction

    function void add_char(input logic [fpdt_pkg::CHAR_W-1:0] ch, input logic last);
        t_text_char item;

        item.ch   = ch;
        item.last = last;
        expected_chars.insert(expected_chars.size(), item);
    endfunction

    function void note_word(input logic [fpdt_pkg::WORD_W-1:0] word);
        longint unsigned frac;
        longint unsigned ipart;
        longint unsigned v;
        longint unsigned pow5;
        int unsigned     digits[20];
        logic [fpdt_pkg::CHAR_W-1:0] ch;
        bit              neg;
        int              n;
        int              keep;
        int              k;
        int              start;

        frac  = word & ((64'd1 << fpdt_pkg::FRAC_BITS_DEF) - 64'd1);
        ipart = (word >> fpdt_pkg::FRAC_BITS_DEF) &
                ((64'd1 << fpdt_pkg::INT_BITS_DEF) - 64'd1);
        neg   = (64'(word) >> (fpdt_pkg::INT_BITS_DEF + fpdt_pkg::FRAC_BITS_DEF)) != 0;
        start = expected_chars.size();
        words_seen++;

        if (neg) begin
            neg_words++;
            add_char(fpdt_pkg::CH_MINUS, 1'b0);
        end

        // Integer digits are produced least significant first.
        n = 0;
        v = ipart;
        do begin
            digits[n] = int'(v % 10);
            v = v / 10;
            n++;
        end while (v != 0);
        for (k = n - 1; k >= 0; k--) begin
            ch = fpdt_pkg::CH_ZERO + 6'(digits[k]);
            add_char(ch, 1'b0);
        end

        add_char(fpdt_pkg::CH_POINT, 1'b0);

        // The fraction is exact: frac * 5^FRAC_BITS written as FRAC_BITS digits.
        pow5 = 1;
        for (k = 0; k < fpdt_pkg::FRAC_BITS_DEF; k++) begin
            pow5 = pow5 * 5;
        end
        v = frac * pow5;
        for (k = fpdt_pkg::FRAC_BITS_DEF - 1; k >= 0; k--) begin
            digits[k] = int'(v % 10);
            v = v / 10;
        end
        keep = fpdt_pkg::FRAC_BITS_DEF;
        while (keep > 1 && digits[keep-1] == 0) begin
            keep--;
        end
        for (k = 0; k < keep; k++) begin
            ch = fpdt_pkg::CH_ZERO + 6'(digits[k]);
            add_char(ch, 1'b0);
        end

        expected_chars[expected_chars.size()-1].last = 1'b1;
        if (expected_chars.size() - start > longest) begin
            longest = expected_chars.size() - start;
        end
    endfunction

    function void check_char(input logic [fpdt_pkg::CHAR_W-1:0] ch, input logic last);
        t_text_char exp_char;

        chars_seen++;
        if (expected_chars.size() == 0) begin
            $error("unexpected character: text_char %0d, last_char %0b", ch, last);
            errors++;
            return;
        end
        exp_char = expected_chars.pop_front();
        if (ch !== exp_char.ch) begin
            $error("text_char: expected %0d, actual %0d", exp_char.ch, ch);
            errors++;
        end
        if (last !== exp_char.last) begin
            $error("last_char: expected %0b, actual %0b", exp_char.last, last);
            errors++;
        end
    endfunction

endclass

module fixed_point_word_to_decimal_text_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fpdt_pkg::*;

    localparam int LATENCY      = 2 + (INT_BITS_DEF + 1) / 2;
    localparam int PHASE_WORDS  = 120;
    localparam int DRAIN_LIMIT  = 50000;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic [WORD_W-1:0]   i_fixed_word = '0;
    logic                i_out_ready  = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [CHAR_W-1:0]   o_text_char;
    logic                o_last_char;

    decimal_text_board board = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    fixed_point_word_to_decimal_text DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_fixed_word (i_fixed_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_text_char  (o_text_char),
        .o_last_char  (o_last_char)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Character side: check what was taken at this edge, then pick next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_char(o_text_char, o_last_char);
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid   <= 1'b0;
            i_fixed_word <= $urandom;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_fixed_word <= word;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        board.note_word(word);
    endtask

    // Hold off the sender until every predicted character has come back, or DRAIN_LIMIT runs out.
    task automatic drain_text();
        int waited;

        waited = 0;
        i_in_valid <= 1'b0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        logic [INT_BITS_DEF-1:0]  ipart;
        logic [FRAC_BITS_DEF-1:0] frac;
        logic                     sign;
        int                       ndig;
        int                       top;

        sign = 1'($urandom_range(1));
        frac = FRAC_BITS_DEF'($urandom);
        ipart = INT_BITS_DEF'($urandom);
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                // Spread the integer part over every digit count.
                ndig = $urandom_range(1, 8);
                top = (ndig == 8) ? (1 << INT_BITS_DEF) - 1 : 10 ** ndig - 1;
                ipart = INT_BITS_DEF'($urandom_range(top));
            end
            2: begin
                // Fractions with many trailing zeros, or none at all.
                frac = ($urandom_range(3) == 0) ? '0 : (7'd1 << $urandom_range(6));
            end
            default: begin
                ipart = $urandom_range(1) ? '0 : INT_BITS_DEF'($urandom_range(9));
            end
        endcase
        return {sign, ipart, frac};
    endfunction

    task automatic run_random(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_word(random_word());
        drain_text();
    endtask

    initial begin
        logic [WORD_W-1:0] directed[$];

        directed = '{
            32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
            32'h0000_0001, 32'h8000_0001, 32'h0000_0040, 32'h0000_0020,
            32'h0000_0010, 32'h0000_0008, 32'h0000_0004, 32'h0000_0002,
            32'h0000_007F, 32'h0000_0080, 32'h8000_0080, 32'h7FFF_FF80,
            (32'd9 << 7), (32'd10 << 7), (32'd99 << 7), (32'd100 << 7),
            (32'd1234567 << 7) | 32'h55, 32'h8000_0000 | (32'd10000000 << 7)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_word(directed[i]);
        end
        drain_text();

        run_random(0, 0, PHASE_WORDS);
        run_random(64, 0, PHASE_WORDS);
        run_random(0, 64, PHASE_WORDS);
        run_random(26, 26, PHASE_WORDS);

        if (board.pending() != 0) begin
            $error("%0d expected characters never arrived", board.pending());
            board.errors++;
        end
        $display("Sent %0d words (%0d negative), checked %0d characters.",
                 board.words_seen, board.neg_words, board.chars_seen);
        $display("Longest text was %0d characters.", board.longest);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

endmodule
